>>> sv/cgk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cgk_pkg;

    localparam int MAX_DIMS  = 8;
    localparam int DIM_W     = 3;
    localparam int MAT_AW    = 2 * DIM_W;
    localparam int VAL_W     = 32;
    localparam int QDEPTH    = 2;
    localparam int EXP_TERMS = 6;

    localparam logic [23:0] LOG2E_HALF = 24'd12102203;
    localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic signed [39:0] Q_LIMIT = 40'sh40_0000_0000;
    localparam logic [31:0] PREFACTOR_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        FUNC_MATRIX = 2'd0,
        FUNC_CENTRE = 2'd1,
        FUNC_DESC   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_PREFACTOR  = 2'd0,
        CFG_IGNORE_EXP = 2'd1,
        CFG_GRAD_DESC  = 2'd2,
        CFG_DIMS       = 2'd3
    } cfg_idx_t;

    localparam logic KIND_KERNEL = 1'b0;
    localparam logic KIND_GRAD   = 1'b1;

    typedef enum logic [1:0] {
        CLS_MATRIX,
        CLS_CENTRE,
        CLS_DESC
    } cls_t;

    typedef struct packed {
        logic [1:0]              func;
        logic [DIM_W-1:0]        row_or_dim;
        logic [DIM_W-1:0]        column;
        logic signed [VAL_W-1:0] value_a;
        logic signed [VAL_W-1:0] value_b;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic                    kind;
        logic [DIM_W-1:0]        dim;
        logic signed [VAL_W-1:0] result_value;
        logic                    last_result;
    } out_item_t;

    typedef struct packed {
        cls_t                    cls;
        logic [DIM_W-1:0]        row_or_dim;
        logic [DIM_W-1:0]        column;
        logic signed [VAL_W-1:0] value_a;
        logic signed [VAL_W-1:0] value_b;
        logic                    last;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE, S_D_MUL, S_D_WB, S_M_RD, S_M_MUL, S_M_ACC, S_Q_MUL, S_Q_ACC,
        S_K_START, S_Y_HI, S_Y_LO, S_Y_SUM, S_H_MUL, S_H_ACC, S_P_MUL, S_P_SH,
        S_EMIT_K, S_G_MUL1, S_G_T, S_G_MUL2, S_G_EMIT
    } state_t;

    function automatic logic [29:0] exp2_coef(input logic [2:0] idx);
        logic [29:0] c;
        case (idx)
            3'd0:    c = 30'd165394;
            3'd1:    c = 30'd1431680;
            3'd2:    c = 30'd10327388;
            3'd3:    c = 30'd59597083;
            3'd4:    c = 30'd257941248;
            3'd5:    c = 30'd744261118;
            default: c = 30'd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [49:0] rnd16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = (p + 66'sd32768) >>> 16;
        return t[49:0];
    endfunction

endpackage
`default_nettype wire

>>> sv/correlated_gaussian_kernel.sv
`timescale 1ns / 1ps
`default_nettype none
// Correlated Gaussian kernel with gradient, signed Q16.16. Matrix and centre
// load transactions are written by the back end once they leave the
// two-entry input queue; a descriptor element is scaled and written back. The
// descriptor element marked last starts the evaluation: the quadratic form
// runs through one shared 33x33 multiplier, term by term for each matrix row,
// then the exponent and scaling (skipped in ignore mode), then the kernel
// value and each of the D gradient terms; an output stall holds the results.
// Configuration writes are registered and must be made while idle.
module correlated_gaussian_kernel (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_data,
    input  cgk_pkg::in_item_t  s_data,
    input  logic               s_valid,
    output logic               s_ready,
    output cgk_pkg::out_item_t m_data,
    output logic               m_valid,
    input  logic               m_ready
);
    import cgk_pkg::*;

    entry_t q_data;
    logic   q_valid, q_ready;

    cgk_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    cgk_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .q_data    (q_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule
`default_nettype wire

>>> sv/cgk_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cgk_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  cgk_pkg::in_item_t s_data,
    input  logic              s_valid,
    output logic              s_ready,
    output cgk_pkg::entry_t   q_data,
    output logic              q_valid,
    input  logic              q_ready
);
    import cgk_pkg::*;

    entry_t     ent_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    entry_t     cls_entry;
    logic       push, pop;

    always_comb begin
        cls_entry.row_or_dim = s_data.row_or_dim;
        cls_entry.column     = s_data.column;
        cls_entry.value_a    = s_data.value_a;
        cls_entry.value_b    = s_data.value_b;
        cls_entry.last       = s_data.last;
        keep                 = 1'b1;
        unique case (s_data.func)
            FUNC_MATRIX: cls_entry.cls = CLS_MATRIX;
            FUNC_CENTRE: cls_entry.cls = CLS_CENTRE;
            FUNC_DESC:   cls_entry.cls = CLS_DESC;
            default: begin
                cls_entry.cls = CLS_DESC;
                keep          = 1'b0;
            end
        endcase
    end

    assign s_ready = (count_reg != 2'(QDEPTH));
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= cls_entry;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QDEPTH)) else $error("queue count out of range");
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("push lost");
    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> count_reg == $past(count_reg) - 2'd1)
        else $error("pop lost");

endmodule
`default_nettype wire

>>> sv/cgk_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cgk_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_data,
    input  cgk_pkg::entry_t    q_data,
    input  logic               q_valid,
    output logic               q_ready,
    output cgk_pkg::out_item_t m_data,
    output logic               m_valid,
    input  logic               m_ready
);
    import cgk_pkg::*;

    logic [31:0] prefactor_reg;
    logic        ignore_reg, grad_desc_reg;
    logic [3:0]  dims_reg;
    logic [DIM_W-1:0] dim_last;

    state_t state_reg, state_next;
    logic [DIM_W-1:0] j_reg, j_next, k_reg, k_next;
    logic [2:0]  i_reg, i_next;
    entry_t      cur_reg, cur_next;
    logic signed [51:0] macc_reg, macc_next;
    logic signed [51:0] qacc_reg, qacc_next;
    logic signed [39:0] qc_reg, qc_next;
    logic signed [65:0] ph_reg, ph_next;
    logic signed [25:0] n_reg, n_next;
    logic [29:0] f30_reg, f30_next;
    logic [29:0] hacc_reg, hacc_next;
    logic [30:0] p_reg, p_next;
    logic [31:0] kval_reg, kval_next;
    logic signed [31:0] t_reg, t_next;
    out_item_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic signed [31:0] diff_reg   [MAX_DIMS];
    logic signed [31:0] mvec_reg   [MAX_DIMS];
    logic signed [31:0] centre_reg [MAX_DIMS];
    logic signed [31:0] rnorm_reg  [MAX_DIMS];
    logic signed [31:0] mat_mem    [MAX_DIMS * MAX_DIMS];
    logic signed [31:0] mat_q_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic        mul_go;

    logic [DIM_W-1:0] diff_idx, rn_idx;
    logic signed [31:0] diff_rd, rn_rd;
    logic signed [51:0] macc_sum;
    logic signed [65:0] p_full, neg_p, y_full;
    logic [29:0] h_term;
    logic signed [31:0] g_val, g_fin;
    logic signed [32:0] d_sub;
    logic signed [26:0] s_val, ns_val;
    logic [63:0] produ;
    logic [64:0] r_full;
    logic [31:0] r_fin;
    logic        out_free, pop;
    logic        diff_we, mvec_we, ctr_we, mat_we;

    always_comb begin
        if (dims_reg == 4'd0) begin
            dim_last = '0;
        end else if (dims_reg > 4'(MAX_DIMS)) begin
            dim_last = DIM_W'(MAX_DIMS - 1);
        end else begin
            dim_last = DIM_W'(dims_reg - 4'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefactor_reg <= PREFACTOR_RESET;
            ignore_reg    <= 1'b0;
            grad_desc_reg <= 1'b0;
            dims_reg      <= 4'(MAX_DIMS);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_PREFACTOR:  prefactor_reg <= cfg_data;
                CFG_IGNORE_EXP: ignore_reg    <= cfg_data[0];
                CFG_GRAD_DESC:  grad_desc_reg <= cfg_data[0];
                CFG_DIMS:       dims_reg      <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign diff_idx = (state_reg == S_M_MUL) ? k_reg : j_reg;
    assign rn_idx   = (state_reg == S_D_MUL) ? cur_reg.row_or_dim : j_reg;
    assign diff_rd  = diff_reg[diff_idx];
    assign rn_rd    = rnorm_reg[rn_idx];
    assign out_free = !out_valid_reg || m_ready;
    assign pop      = q_valid && q_ready;
    assign q_ready  = (state_reg == S_IDLE);

    assign d_sub    = 33'(cur_reg.value_a) - 33'(centre_reg[cur_reg.row_or_dim]);
    assign macc_sum = macc_reg + 52'(rnd16(prod_reg));
    assign p_full   = (ph_reg <<< 16) + prod_reg;
    assign neg_p    = -p_full;
    assign y_full   = neg_p >>> 24;
    assign h_term   = prod_reg[59:30];

    always_comb begin
        g_val = sat32(66'(rnd16(prod_reg)));
        g_fin = g_val;
        if (grad_desc_reg) begin
            g_fin = (g_val == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -g_val;
        end
    end

    always_comb begin
        produ  = prod_reg[63:0];
        s_val  = 27'sd30 - 27'(n_reg);
        ns_val = -s_val;
        if (produ == 64'd0 || s_val >= 27'sd64) begin
            r_full = 65'd0;
        end else if (s_val > 27'sd0) begin
            r_full = ((65'(produ) >> 6'(s_val - 27'sd1)) + 65'd1) >> 1;
        end else if (ns_val >= 27'sd32
                     || produ > (64'h7FFF_FFFF >> ns_val[4:0])) begin
            r_full = 65'h7FFF_FFFF;
        end else begin
            r_full = 65'(produ << ns_val[4:0]);
        end
        if (r_full > 65'h7FFF_FFFF) begin
            r_fin = 32'h7FFF_FFFF;
        end else begin
            r_fin = r_full[31:0];
        end
        if (r_fin == 32'd0) begin
            r_fin = 32'd1;
        end
    end

    always_comb begin
        state_next     = state_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        cur_next       = cur_reg;
        macc_next      = macc_reg;
        qacc_next      = qacc_reg;
        qc_next        = qc_reg;
        ph_next        = ph_reg;
        n_next         = n_reg;
        f30_next       = f30_reg;
        hacc_next      = hacc_reg;
        p_next         = p_reg;
        kval_next      = kval_reg;
        t_next         = t_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        mul_a          = '0;
        mul_b          = '0;
        mul_go         = 1'b0;
        diff_we        = 1'b0;
        mvec_we        = 1'b0;
        ctr_we         = 1'b0;
        mat_we         = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    cur_next = q_data;
                    unique case (q_data.cls)
                        CLS_MATRIX: mat_we = 1'b1;
                        CLS_CENTRE: ctr_we = 1'b1;
                        CLS_DESC:   state_next = S_D_MUL;
                        default: ;
                    endcase
                end
            end
            S_D_MUL: begin
                mul_a      = 33'(sat32(66'(d_sub)));
                mul_b      = 33'(rn_rd);
                mul_go     = 1'b1;
                state_next = S_D_WB;
            end
            S_D_WB: begin
                diff_we    = 1'b1;
                j_next     = '0;
                k_next     = '0;
                macc_next  = '0;
                qacc_next  = '0;
                state_next = cur_reg.last ? S_M_RD : S_IDLE;
            end
            S_M_RD: state_next = S_M_MUL;
            S_M_MUL: begin
                mul_a      = 33'(mat_q_reg);
                mul_b      = 33'(diff_rd);
                mul_go     = 1'b1;
                state_next = S_M_ACC;
            end
            S_M_ACC: begin
                macc_next = macc_sum;
                if (k_reg == dim_last) begin
                    mvec_we    = 1'b1;
                    state_next = S_Q_MUL;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_M_RD;
                end
            end
            S_Q_MUL: begin
                mul_a      = 33'(diff_rd);
                mul_b      = 33'(mvec_reg[j_reg]);
                mul_go     = 1'b1;
                state_next = S_Q_ACC;
            end
            S_Q_ACC: begin
                qacc_next = qacc_reg + 52'(rnd16(prod_reg));
                macc_next = '0;
                k_next    = '0;
                if (j_reg == dim_last) begin
                    state_next = S_K_START;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_M_RD;
                end
            end
            S_K_START: begin
                if (ignore_reg) begin
                    kval_next  = ONE_Q16;
                    state_next = S_EMIT_K;
                end else begin
                    if (qacc_reg > 52'(Q_LIMIT)) begin
                        qc_next = Q_LIMIT;
                    end else if (qacc_reg < -52'(Q_LIMIT)) begin
                        qc_next = -Q_LIMIT;
                    end else begin
                        qc_next = qacc_reg[39:0];
                    end
                    state_next = S_Y_HI;
                end
            end
            S_Y_HI: begin
                mul_a      = 33'(qc_reg >>> 16);
                mul_b      = {9'd0, LOG2E_HALF};
                mul_go     = 1'b1;
                state_next = S_Y_LO;
            end
            S_Y_LO: begin
                ph_next    = prod_reg;
                mul_a      = {17'd0, qc_reg[15:0]};
                mul_b      = {9'd0, LOG2E_HALF};
                mul_go     = 1'b1;
                state_next = S_Y_SUM;
            end
            S_Y_SUM: begin
                n_next     = y_full[41:16];
                f30_next   = {y_full[15:0], 14'd0};
                hacc_next  = exp2_coef(3'd0);
                i_next     = 3'd1;
                state_next = S_H_MUL;
            end
            S_H_MUL: begin
                mul_a      = {3'd0, hacc_reg};
                mul_b      = {3'd0, f30_reg};
                mul_go     = 1'b1;
                state_next = S_H_ACC;
            end
            S_H_ACC: begin
                if (i_reg < 3'(EXP_TERMS)) begin
                    hacc_next  = exp2_coef(i_reg) + h_term;
                    i_next     = i_reg + 3'd1;
                    state_next = S_H_MUL;
                end else begin
                    p_next     = ONE_Q30 + 31'(h_term);
                    state_next = S_P_MUL;
                end
            end
            S_P_MUL: begin
                mul_a      = {1'b0, prefactor_reg};
                mul_b      = {2'd0, p_reg};
                mul_go     = 1'b1;
                state_next = S_P_SH;
            end
            S_P_SH: begin
                kval_next  = r_fin;
                state_next = S_EMIT_K;
            end
            S_EMIT_K: begin
                if (out_free) begin
                    out_next.kind         = KIND_KERNEL;
                    out_next.dim          = '0;
                    out_next.result_value = kval_reg;
                    out_next.last_result  = 1'b0;
                    out_valid_next        = 1'b1;
                    j_next                = '0;
                    state_next            = S_G_MUL1;
                end
            end
            S_G_MUL1: begin
                mul_a      = {1'b0, kval_reg};
                mul_b      = 33'(mvec_reg[j_reg]);
                mul_go     = 1'b1;
                state_next = S_G_T;
            end
            S_G_T: begin
                t_next     = sat32(66'(rnd16(prod_reg)));
                state_next = S_G_MUL2;
            end
            S_G_MUL2: begin
                mul_a      = 33'(t_reg);
                mul_b      = 33'(rn_rd);
                mul_go     = 1'b1;
                state_next = S_G_EMIT;
            end
            S_G_EMIT: begin
                if (out_free) begin
                    out_next.kind         = KIND_GRAD;
                    out_next.dim          = j_reg;
                    out_next.result_value = g_fin;
                    out_next.last_result  = (j_reg == dim_last);
                    out_valid_next        = 1'b1;
                    if (j_reg == dim_last) begin
                        state_next = S_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_G_MUL1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int e = 0; e < MAX_DIMS; e++) begin
                diff_reg[e] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (diff_we && int'(cur_reg.row_or_dim) < MAX_DIMS) begin
                diff_reg[cur_reg.row_or_dim] <= sat32(66'(rnd16(prod_reg)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        j_reg    <= j_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        cur_reg  <= cur_next;
        macc_reg <= macc_next;
        qacc_reg <= qacc_next;
        qc_reg   <= qc_next;
        ph_reg   <= ph_next;
        n_reg    <= n_next;
        f30_reg  <= f30_next;
        hacc_reg <= hacc_next;
        p_reg    <= p_next;
        kval_reg <= kval_next;
        t_reg    <= t_next;
        out_reg  <= out_next;
        if (mul_go) begin
            prod_reg <= mul_a * mul_b;
        end
        if (mvec_we) begin
            mvec_reg[j_reg] <= sat32(66'(macc_sum));
        end
        if (ctr_we) begin
            centre_reg[q_data.row_or_dim] <= q_data.value_a;
            rnorm_reg[q_data.row_or_dim]  <= q_data.value_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (mat_we) begin
            mat_mem[{q_data.row_or_dim, q_data.column}] <= q_data.value_a;
        end
        if (state_reg == S_M_RD) begin
            mat_q_reg <= mat_mem[{j_reg, k_reg}];
        end
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> state_reg == S_IDLE) else $error("queue popped while busy");
    a_kernel_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_KERNEL |-> m_data.dim == '0 && !m_data.last_result)
        else $error("kernel result fields wrong");
    a_scale_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_P_SH |-> $past(state_reg) == S_P_MUL)
        else $error("scale step out of order");

endmodule
`default_nettype wire

>>> verif/cgk_checker.sv
`timescale 1ns / 1ps
module cgk_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_data,
    input  cgk_pkg::in_item_t  s_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  cgk_pkg::out_item_t m_data,
    input  logic               m_valid,
    input  logic               m_ready,
    output int                 fail_count,
    output int                 pending_results
);
    import cgk_pkg::*;

    logic [31:0] prefactor_q;
    logic        ignore_q;
    logic        negate_q;
    logic [3:0]  dims_q;
    longint      mat [64];
    longint      centre [8];
    longint      rnorm [8];
    longint      diff [8];
    out_item_t   expected_q [$];

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic longint round16(longint p);
        return asr(p + 32768, 16);
    endfunction

    function automatic longint kernel_of(longint q);
        longint y, n, s;
        longint unsigned f30, acc, p, prod, r;
        longint unsigned coef [6];
        coef = '{165394, 1431680, 10327388, 59597083, 257941248, 744261118};
        if (q > (64'sd1 <<< 38)) q = 64'sd1 <<< 38;
        if (q < -(64'sd1 <<< 38)) q = -(64'sd1 <<< 38);
        y = asr(-(q * 12102203), 24);
        n = asr(y, 16);
        f30 = longint'(y - n * 65536) << 14;
        acc = coef[0];
        for (int i = 1; i < 6; i++) acc = coef[i] + ((acc * f30) >> 30);
        p = (64'd1 << 30) + ((acc * f30) >> 30);
        prod = longint'(prefactor_q) * p;
        s = 30 - n;
        if (prod == 0 || s >= 64) r = 0;
        else if (s > 0) r = ((prod >> (s - 1)) + 1) >> 1;
        else if (-s >= 32 || prod > (64'h7FFF_FFFF >> (-s))) r = 64'h7FFF_FFFF;
        else r = prod << (-s);
        if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
        if (r == 0) r = 1;
        return longint'(r);
    endfunction

    task automatic predict_point(in_item_t it);
        longint m [8];
        longint q, kv, acc, t, g;
        int d;
        out_item_t o;
        q = 0;
        if (func_t'(it.func) == FUNC_MATRIX) begin
            mat[{it.row_or_dim, it.column}] = it.value_a;
            return;
        end
        if (func_t'(it.func) == FUNC_CENTRE) begin
            centre[it.row_or_dim] = it.value_a;
            rnorm[it.row_or_dim] = it.value_b;
            return;
        end
        if (func_t'(it.func) != FUNC_DESC) return;
        diff[it.row_or_dim] = clamp32(round16(clamp32(longint'(it.value_a)
            - centre[it.row_or_dim]) * rnorm[it.row_or_dim]));
        if (!it.last) return;
        d = dims_q;
        if (d < 1) d = 1;
        if (d > 8) d = 8;
        for (int j = 0; j < d; j++) begin
            acc = 0;
            for (int k = 0; k < d; k++) acc += round16(mat[j * 8 + k] * diff[k]);
            m[j] = clamp32(acc);
            q += round16(diff[j] * m[j]);
        end
        kv = ignore_q ? 65536 : kernel_of(q);
        o = '0;
        o.kind = KIND_KERNEL;
        o.result_value = kv[31:0];
        expected_q = {expected_q, o};
        for (int j = 0; j < d; j++) begin
            t = clamp32(round16(kv * m[j]));
            g = clamp32(round16(t * rnorm[j]));
            if (negate_q) g = clamp32(-g);
            o.kind = KIND_GRAD;
            o.dim = j;
            o.result_value = g[31:0];
            o.last_result = (j == d - 1);
            expected_q = {expected_q, o};
        end
    endtask

    always @(posedge aclk) begin
        out_item_t e;
        int errs;
        errs = 0;
        if (!aresetn) begin
            prefactor_q = PREFACTOR_RESET;
            ignore_q = 1'b0;
            negate_q = 1'b0;
            dims_q = 4'd8;
            fail_count <= 0;
            pending_results <= 0;
            for (int i = 0; i < 8; i++) diff[i] = 0;
            for (int i = 0; i < 8; i++) centre[i] = 0;
            for (int i = 0; i < 8; i++) rnorm[i] = 0;
            for (int i = 0; i < 64; i++) mat[i] = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_PREFACTOR:  prefactor_q = cfg_data;
                    CFG_IGNORE_EXP: ignore_q = cfg_data[0];
                    CFG_GRAD_DESC:  negate_q = cfg_data[0];
                    CFG_DIMS:       dims_q = cfg_data[3:0];
                endcase
            end
            if (s_valid && s_ready) predict_point(s_data);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction %p", m_data);
                    errs = errs + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (m_data.kind !== e.kind) begin
                        $error("kind: expected %0d actual %0d", e.kind, m_data.kind);
                        errs = errs + 1;
                    end
                    if (m_data.dim !== e.dim) begin
                        $error("dim: expected %0d actual %0d", e.dim, m_data.dim);
                        errs = errs + 1;
                    end
                    if (m_data.result_value !== e.result_value) begin
                        $error("result_value: expected %h actual %h",
                               e.result_value, m_data.result_value);
                        errs = errs + 1;
                    end
                    if (m_data.last_result !== e.last_result) begin
                        $error("last_result: expected %0d actual %0d",
                               e.last_result, m_data.last_result);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending_results <= expected_q.size();
        end
    end
endmodule

>>> verif/correlated_gaussian_kernel_tb.sv
`timescale 1ns / 1ps
module correlated_gaussian_kernel_tb;
    import cgk_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [31:0] cfg_data = '0;
    in_item_t  s_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    out_item_t m_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    int        fail_count;
    int        pending_results;
    bit        quiet_mode = 0;
    bit        hold_sink = 0;
    int        idle_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    correlated_gaussian_kernel i_dut (.*);

    cgk_checker i_checker (.*);

    task automatic send(func_t f, int rd, int col, logic [31:0] a, logic [31:0] b,
                        logic lst);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_data <= '{func: f, row_or_dim: rd, column: col, value_a: a,
                    value_b: b, last: lst};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] small_val();
        return $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 262143)) - 131072;
    endfunction

    // full table load: moderate matrix values, then all eight centres
    task automatic load_tables(int d);
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
                send(FUNC_MATRIX, r, c, (r == c) ? 32'h0001_0000 + $urandom_range(0, 65535)
                     : $signed($urandom_range(0, 32768)) - 16384, 0, 0);
        for (int i = 0; i < 8; i++)
            send(FUNC_CENTRE, i, 0, small_val(), $urandom_range(1, 131072), 0);
    endtask

    task automatic send_point(int d);
        for (int i = 0; i < d; i++)
            send(FUNC_DESC, i, $urandom_range(0, 7), small_val(), $urandom,
                 i == d - 1);
    endtask

    always @(posedge aclk) begin
        if (!aresetn || quiet_mode) m_ready <= 1'b1;
        else if (hold_sink) m_ready <= 1'b0;
        else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            idle_cycles <= $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else m_ready <= 1'b1;
    end

    int stuck = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !s_valid && pending_results == 0)
            stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck > 20000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int d;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        load_tables(8);
        // directed: extremes, ignore mode, negation, unused code, out-of-range dims
        send(FUNC_DESC, 0, 0, 32'h7FFF_FFFF, 0, 0);
        send(FUNC_DESC, 1, 7, 32'h8000_0000, 0, 0);
        send(FUNC_NONE, 7, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send(FUNC_MATRIX, 7, 7, 32'h0001_0000, 32'hFFFF_FFFF, 1);
        send_point(8);
        drain();
        write_reg(CFG_PREFACTOR, 32'hFFFF_FFFF);
        write_reg(CFG_IGNORE_EXP, 1);
        write_reg(CFG_GRAD_DESC, 1);
        write_reg(CFG_DIMS, 0);
        send_point(1);
        drain();
        write_reg(CFG_IGNORE_EXP, 0);
        write_reg(CFG_DIMS, 15);
        send_point(8);
        drain();
        write_reg(CFG_PREFACTOR, 0);
        write_reg(CFG_DIMS, 3);
        send_point(3);
        drain();
        // long receiver hold-off while the sender keeps offering
        hold_sink = 1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_sink = 0;
            end
            begin
                send_point(3);
                send_point(3);
                send_point(3);
            end
        join
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            d = (ph == 3) ? 8 : $urandom_range(1, 4);
            write_reg(CFG_DIMS, d);
            write_reg(CFG_PREFACTOR, $urandom_range(0, 1) ? 32'h0001_0000 : $urandom);
            write_reg(CFG_GRAD_DESC, $urandom_range(0, 1));
            write_reg(CFG_IGNORE_EXP, $urandom_range(0, 3) == 0);
            if (ph == 3) quiet_mode = 1;
            for (int p = 0; p < 4; p++) begin
                if ($urandom_range(0, 4) == 0)
                    send(FUNC_CENTRE, $urandom_range(0, 7), 0, small_val(),
                         $urandom_range(1, 131072), 0);
                if ($urandom_range(0, 9) == 0)
                    send(FUNC_NONE, $urandom_range(0, 7), 0, $urandom, $urandom, 1);
                if ($urandom_range(0, 4) == 0)
                    send(FUNC_MATRIX, $urandom_range(0, 7), $urandom_range(0, 7),
                         small_val(), $urandom, $urandom_range(0, 1));
                send_point(d);
            end
            drain();
        end
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
